>>> hdl/ssp_pkg.sv
// shared types and constants for the sprite screen projection block
// no dependencies
package ssp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 512;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INV_FOV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 1'd1;

    localparam logic [15:0] INV_FOV_RESET = 16'd6206;
    localparam logic [15:0] NEAR_RESET    = 16'd102;

    localparam int HALF_W_W = 12;
    localparam int QUO_W    = 17;
    localparam int DEPTH_W  = 33;
    localparam int NUM_W    = 64;

    typedef struct packed {
        logic        [15:0] sprite_x;
        logic        [15:0] sprite_y;
        logic        [15:0] viewer_x;
        logic        [15:0] viewer_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic        [9:0]  center_row;
    } ssp_item_t;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] left_col;
        logic signed [15:0] top_row;
        logic        [11:0] sprite_width;
        logic        [11:0] sprite_height;
    } ssp_result_t;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic               neg;
        logic [9:0]         center_row;
        logic [DEPTH_W-1:0] depth;
        logic [NUM_W-1:0]   num_abs;
    } ssp_front_t;

endpackage

>>> hdl/sprite_screen_projection.sv
// sprite billboard projection, top level: config registers, dividers, output stage
// one item per cycle sustained unless result_stall holds a waiting result,
// throughput set by the fully pipelined dividers (one quotient bit per stage)
// the whole pipeline holds while a result waits under stall
// reset clears valid bits and loads the register defaults
// depends on ssp_pkg, ssp_front, ssp_div_pipe
module sprite_screen_projection #(
    parameter int SCREEN_WIDTH  = ssp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ssp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  ssp_pkg::ssp_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ssp_pkg::ssp_result_t               result,
    input  logic                               cfg_wr_en,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ssp_pkg::*;

    localparam logic [34:0] H_NUM   = 35'(SCREEN_HEIGHT) << 22;
    localparam int          H_LIM_I = (4 * SCREEN_HEIGHT > 4095) ? 4095 : 4 * SCREEN_HEIGHT;
    localparam logic [11:0] H_LIM   = 12'(H_LIM_I);
    localparam logic [16:0] W_LIM   = 17'(4 * SCREEN_WIDTH);

    logic [15:0] inv_fov_reg, near_reg;
    logic        result_valid_reg;
    ssp_result_t result_reg;
    logic        adv;

    ssp_front_t  front;
    logic [QUO_W-1:0] quo_h, quo_c;
    logic [9:0]  crow_d;
    logic [2:0]  ctl_d;

    logic [11:0]        h_val, w_val;
    logic [23:0]        third_prod;
    logic [10:0]        third;
    logic signed [17:0] centre;
    logic signed [18:0] left_wide;
    logic signed [15:0] left_sat, top_val;
    ssp_result_t        result_next;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_fov_reg <= INV_FOV_RESET;
            near_reg    <= NEAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_INV_FOV: inv_fov_reg <= cfg_data;
                REG_NEAR:    near_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    ssp_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .valid         (item_valid),
        .item          (item),
        .inv_fov_scale (inv_fov_reg),
        .near_limit    (near_reg),
        .front         (front)
    );

    ssp_div_pipe #(
        .NUM_W  (35),
        .DEN_W  (DEPTH_W),
        .Q_W    (QUO_W),
        .SIDE_W (10)
    ) u_div_height (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (H_NUM),
        .den      (front.depth),
        .side_in  (front.center_row),
        .quo      (quo_h),
        .side_out (crow_d)
    );

    ssp_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEPTH_W + 12),
        .Q_W    (QUO_W),
        .SIDE_W (3)
    ) u_div_column (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (front.num_abs),
        .den      ({front.depth, 12'b0}),
        .side_in  ({front.valid, front.visible, front.neg}),
        .quo      (quo_c),
        .side_out (ctl_d)
    );

    always_comb
    begin
        h_val      = (quo_h > 17'(H_LIM)) ? H_LIM : quo_h[11:0];
        w_val      = (17'(h_val) > W_LIM) ? W_LIM[11:0] : h_val;
        // divide by three via reciprocal, exact below 4096
        third_prod = h_val * 12'd2731;
        third      = third_prod[23:13];
        centre     = ctl_d[0] ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
        left_wide  = 19'(centre) - $signed({8'b0, w_val[11:1]});
        if (left_wide > 19'sd32767)
        begin
            left_sat = 16'sh7fff;
        end
        else if (left_wide < -19'sd32768)
        begin
            left_sat = -16'sh8000;
        end
        else
        begin
            left_sat = left_wide[15:0];
        end
        top_val = $signed({6'b0, crow_d}) - $signed({5'b0, third});

        result_next = '0;
        if (ctl_d[1])
        begin
            result_next.visible       = 1'b1;
            result_next.left_col      = left_sat;
            result_next.top_row       = top_val;
            result_next.sprite_width  = w_val;
            result_next.sprite_height = h_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= ctl_d[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.visible |->
            result.sprite_width == 12'd0 && result.sprite_height == 12'd0 &&
            result.left_col == 16'sd0 && result.top_row == 16'sd0)
        else $error("culled result carries nonzero fields");

    a_width_le_height: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.visible |-> result.sprite_width <= result.sprite_height)
        else $error("sprite width exceeds height");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a blocked result");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> $stable(result_valid))
        else $error("pipeline moved while stalled");

endmodule

>>> hdl/ssp_front.sv
// front pipeline: offsets, dot and cross products, cull test, column numerator
// depends on ssp_pkg
module ssp_front #(
    parameter int SCREEN_WIDTH = ssp_pkg::SCREEN_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid,
    input  ssp_pkg::ssp_item_t item,
    input  logic [15:0]        inv_fov_scale,
    input  logic [15:0]        near_limit,
    output ssp_pkg::ssp_front_t front
);
    import ssp_pkg::*;

    localparam logic [HALF_W_W-1:0] HALF_W = HALF_W_W'(SCREEN_WIDTH / 2);

    logic [6:0] valid_reg;

    logic signed [16:0] dx1_reg, dy1_reg;
    logic signed [15:0] ux1_reg, uy1_reg;
    logic [9:0]         crow_reg [1:6];

    logic signed [32:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [33:0] depth3_reg, cross3_reg;

    logic               vis_reg [4:6];
    logic signed [33:0] depth4_reg;
    logic signed [50:0] prod4_reg;

    logic [DEPTH_W-1:0] depth_reg [5:6];
    logic               neg_reg [5:6];
    logic [51:0]        mag5_reg;

    logic [37:0]        lo6_reg, hi6_reg;

    logic               vis7_reg, neg7_reg;
    logic [9:0]         crow7_reg;
    logic [DEPTH_W-1:0] depth7_reg;
    logic [NUM_W-1:0]   num7_reg;

    logic signed [51:0] diff5;
    logic signed [34:0] near_ext;

    assign near_ext = $signed({5'b0, near_limit, 14'b0});
    assign diff5 = $signed({{6{depth4_reg[33]}}, depth4_reg, 12'b0})
                 - $signed({prod4_reg[50], prod4_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offsets
            dx1_reg     <= $signed({1'b0, item.sprite_x}) - $signed({1'b0, item.viewer_x});
            dy1_reg     <= $signed({1'b0, item.sprite_y}) - $signed({1'b0, item.viewer_y});
            ux1_reg     <= item.dir_x;
            uy1_reg     <= item.dir_y;
            crow_reg[1] <= item.center_row;
            // products
            p0_reg      <= ux1_reg * dx1_reg;
            p1_reg      <= uy1_reg * dy1_reg;
            p2_reg      <= uy1_reg * dx1_reg;
            p3_reg      <= ux1_reg * dy1_reg;
            crow_reg[2] <= crow_reg[1];
            // depth and cross
            depth3_reg  <= 34'(p0_reg) + 34'(p1_reg);
            cross3_reg  <= 34'(p2_reg) - 34'(p3_reg);
            crow_reg[3] <= crow_reg[2];
            // cull and lateral scale
            vis_reg[4]  <= $signed({depth3_reg[33], depth3_reg}) > near_ext;
            depth4_reg  <= depth3_reg;
            prod4_reg   <= $signed({1'b0, inv_fov_scale}) * cross3_reg;
            crow_reg[4] <= crow_reg[3];
            // numerator before the half width scale
            vis_reg[5]   <= vis_reg[4];
            depth_reg[5] <= depth4_reg[DEPTH_W-1:0];
            neg_reg[5]   <= diff5[51];
            mag5_reg     <= diff5[51] ? 52'(-diff5) : 52'(diff5);
            crow_reg[5]  <= crow_reg[4];
            // half width partial products
            lo6_reg      <= mag5_reg[25:0] * HALF_W;
            hi6_reg      <= mag5_reg[51:26] * HALF_W;
            vis_reg[6]   <= vis_reg[5];
            depth_reg[6] <= depth_reg[5];
            neg_reg[6]   <= neg_reg[5];
            crow_reg[6]  <= crow_reg[5];
            // numerator magnitude
            num7_reg     <= {26'b0, lo6_reg} + {hi6_reg, 26'b0};
            vis7_reg     <= vis_reg[6];
            depth7_reg   <= depth_reg[6];
            neg7_reg     <= neg_reg[6];
            crow7_reg    <= crow_reg[6];
        end
    end

    assign front.valid      = valid_reg[6];
    assign front.visible    = vis7_reg;
    assign front.neg        = neg7_reg;
    assign front.center_row = crow7_reg;
    assign front.depth      = depth7_reg;
    assign front.num_abs    = num7_reg;

endmodule

>>> hdl/ssp_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// depends on nothing
module ssp_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 45,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);
    localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [REM_W-1:0]  rem_reg  [0:Q_W];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic [Q_W-1:0]    quo_reg  [0:Q_W];
    logic              sat_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];

    logic [REM_W-1:0] num_ext, den_ext;

    assign num_ext = {{(REM_W-NUM_W){1'b0}}, num};
    assign den_ext = {{(REM_W-DEN_W){1'b0}}, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= num_ext >= (den_ext << Q_W);
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        localparam int B = Q_W - k;
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = {{(REM_W-DEN_W){1'b0}}, den_reg[k-1]} << B;
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | ({{(Q_W-1){1'b0}}, take} << B);
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quo      = sat_reg[Q_W] ? {Q_W{1'b1}} : quo_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule
